// File: rtl/core/lmgs_pkg.sv
// Package for the LED matrix glyph scroller: sizes, codes and payload types.
package lmgs_pkg;

  localparam int unsigned SIDE        = 8;
  localparam int unsigned PIXEL_COUNT = SIDE * SIDE;
  localparam int unsigned IDX_W       = $clog2(PIXEL_COUNT);
  localparam int unsigned POS_W       = $clog2(SIDE);
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned COLOR_W     = 3 * LEVEL_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_UP    = 2'd2;
  localparam logic [1:0] MODE_DOWN  = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_DOWN,
    OP_ROTATE
  } shift_op_e;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } cell_pos_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        glyph_rows;
    logic [POS_W-1:0]   step_index;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } step_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [LEVEL_W-1:0] pixel_red;
    logic [LEVEL_W-1:0] pixel_green;
    logic [LEVEL_W-1:0] pixel_blue;
    logic               frame_last;
  } pixel_t;

endpackage

// File: rtl/core/led_matrix_glyph_scroller_top.sv
// Top level of the LED matrix glyph scroller: request sequencing and pixel stream.
//
//   channel | direction | handshake                  | payload
//   request | in        | req_valid_i / req_ready_o  | req_i (step_req_t)
//   pixel   | out       | pix_valid_o / pix_ready_i  | pix_o (pixel_t)
//
// A request is taken while idle; the grid shifts in that same cycle.
// The frame then streams as 64 pixels, one per accepted cycle: the chain of all
// 64 cells rotates by one per pixel.
// Stalls on the pixel side hold the rotation and the counter.
// Reset clears all 64 cells to black at once and leaves the block idle.
module led_matrix_glyph_scroller_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  lmgs_pkg::step_req_t req_i,
  output logic                pix_valid_o,
  input  logic                pix_ready_i,
  output lmgs_pkg::pixel_t    pix_o
);
  import lmgs_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic               state_d, state_q;
  logic [IDX_W-1:0]   cnt_d, cnt_q;
  shift_op_e          op;
  logic [COLOR_W-1:0] head;
  logic               req_fire, pix_fire;

  assign req_ready_o = (state_q == ST_IDLE);
  assign pix_valid_o = (state_q == ST_STREAM);
  assign req_fire    = req_valid_i && req_ready_o;
  assign pix_fire    = pix_valid_o && pix_ready_i;

  always_comb begin
    op = OP_HOLD;
    if (req_fire) begin
      unique case (req_i.mode)
        MODE_LEFT:  op = OP_LEFT;
        MODE_RIGHT: op = OP_RIGHT;
        MODE_UP:    op = OP_UP;
        MODE_DOWN:  op = OP_DOWN;
        default:    op = OP_HOLD;
      endcase
    end else if (pix_fire) begin
      op = OP_ROTATE;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (req_fire) begin
      state_d = ST_STREAM;
      cnt_d   = '0;
    end else if (pix_fire) begin
      cnt_d = cnt_q + IDX_W'(1);
      if (cnt_q == LAST_IDX) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  lmgs_grid u_grid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .req_i  (req_i),
    .head_o (head)
  );

  assign pix_o.pixel_index = cnt_q;
  assign pix_o.pixel_red   = head[2*LEVEL_W +: LEVEL_W];
  assign pix_o.pixel_green = head[LEVEL_W +: LEVEL_W];
  assign pix_o.pixel_blue  = head[0 +: LEVEL_W];
  assign pix_o.frame_last  = (cnt_q == LAST_IDX);

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && pix_ready_i && pix_o.frame_last |=> !pix_valid_o && req_ready_o)
    else $error("stream did not end after last pixel");

  a_frame_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> pix_valid_o && pix_o.pixel_index == '0)
    else $error("frame did not start at pixel zero");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && pix_ready_i && !pix_o.frame_last
      |=> pix_valid_o && pix_o.pixel_index == $past(pix_o.pixel_index) + IDX_W'(1))
    else $error("pixel index skipped");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o != pix_valid_o)
    else $error("request taken while streaming");

endmodule

// File: rtl/core/lmgs_cell.sv
// One frame pixel: 24-bit colour register that holds or loads a neighbor or edge.
module lmgs_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lmgs_pkg::shift_op_e     op_i,
  input  lmgs_pkg::cell_pos_t     pos_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] east_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] west_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] north_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] south_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] next_i,
  input  logic [lmgs_pkg::COLOR_W-1:0] edge_i,
  output logic [lmgs_pkg::COLOR_W-1:0] pix_o
);
  import lmgs_pkg::*;

  logic [COLOR_W-1:0] pix_d, pix_q;

  always_comb begin
    unique case (op_i)
      OP_LEFT:   pix_d = pos_i.last_col  ? edge_i : east_i;
      OP_RIGHT:  pix_d = pos_i.first_col ? edge_i : west_i;
      OP_UP:     pix_d = pos_i.first_row ? edge_i : north_i;
      OP_DOWN:   pix_d = pos_i.last_row  ? edge_i : south_i;
      OP_ROTATE: pix_d = next_i;
      default:   pix_d = pix_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// File: rtl/core/lmgs_grid.sv
// 8x8 grid of pixel cells with the entering-edge colour logic.
module lmgs_grid (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lmgs_pkg::shift_op_e     op_i,
  input  lmgs_pkg::step_req_t     req_i,
  output logic [lmgs_pkg::COLOR_W-1:0] head_o
);
  import lmgs_pkg::*;

  logic [COLOR_W-1:0] pix      [PIXEL_COUNT];
  logic [COLOR_W-1:0] row_edge [SIDE];
  logic [COLOR_W-1:0] col_edge [SIDE];
  logic [COLOR_W-1:0] colour;

  assign colour = {req_i.red_level, req_i.green_level, req_i.blue_level};

  always_comb begin
    for (int k = 0; k < SIDE; k++) begin
      if (req_i.mode == MODE_LEFT) begin
        row_edge[k] = req_i.glyph_rows[{POS_W'(k), req_i.step_index}] ? colour : '0;
      end else begin
        row_edge[k] = req_i.glyph_rows[{POS_W'(k), ~req_i.step_index}] ? colour : '0;
      end
      if (req_i.mode == MODE_UP) begin
        col_edge[k] = req_i.glyph_rows[{~req_i.step_index, POS_W'(k)}] ? colour : '0;
      end else begin
        col_edge[k] = req_i.glyph_rows[{req_i.step_index, POS_W'(k)}] ? colour : '0;
      end
    end
  end

  for (genvar p = 0; p < PIXEL_COUNT; p++) begin : g_cell
    localparam int unsigned R = p / SIDE;
    localparam int unsigned C = p % SIDE;
    cell_pos_t          pos;
    logic [COLOR_W-1:0] east, west, north, south, next, edge_val;

    assign pos.first_col = (C == 0);
    assign pos.last_col  = (C == SIDE - 1);
    assign pos.first_row = (R == 0);
    assign pos.last_row  = (R == SIDE - 1);

    assign east  = (C == SIDE - 1) ? '0 : pix[(p + 1) % PIXEL_COUNT];
    assign west  = (C == 0) ? '0 : pix[(p + PIXEL_COUNT - 1) % PIXEL_COUNT];
    assign north = (R == 0) ? '0 : pix[(p + PIXEL_COUNT - SIDE) % PIXEL_COUNT];
    assign south = (R == SIDE - 1) ? '0 : pix[(p + SIDE) % PIXEL_COUNT];
    assign next  = pix[(p + 1) % PIXEL_COUNT];
    assign edge_val = req_i.mode[1] ? col_edge[C] : row_edge[R];

    lmgs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op_i),
      .pos_i   (pos),
      .east_i  (east),
      .west_i  (west),
      .north_i (north),
      .south_i (south),
      .next_i  (next),
      .edge_i  (edge_val),
      .pix_o   (pix[p])
    );
  end

  assign head_o = pix[0];

endmodule

// File: dv/led_matrix_glyph_scroller_top_tb.sv
// Testbench for the LED matrix glyph scroller: scroll steps in, checked pixel frames out.
`timescale 1ns / 1ps

module led_matrix_glyph_scroller_top_tb;
  import lmgs_pkg::*;

  localparam int unsigned LAST_POS   = SIDE - 1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 80;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      req_valid_i = 1'b0;
  logic      req_ready_o;
  step_req_t req_i = '0;
  logic      pix_valid_o;
  logic      pix_ready_i = 1'b0;
  pixel_t    pix_o;

  logic [COLOR_W-1:0] frame_shadow [PIXEL_COUNT];
  pixel_t             pending_pixels [$];
  int                 error_count = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int unsigned        quiet_cycles = 0;

  led_matrix_glyph_scroller_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .pix_valid_o (pix_valid_o),
    .pix_ready_i (pix_ready_i),
    .pix_o       (pix_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pix_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // shift the shadow frame one step and queue the 64 pixels it should stream
  function automatic void scroll_frame(step_req_t r);
    logic [COLOR_W-1:0] colour;
    logic [POS_W-1:0]   s;
    pixel_t             px;
    int                 k;
    int                 j;
    int                 p;
    colour = {r.red_level, r.green_level, r.blue_level};
    s = r.step_index;
    for (k = 0; k < SIDE; k++) begin
      case (r.mode)
        MODE_LEFT: begin
          for (j = 0; j < LAST_POS; j++) frame_shadow[k*SIDE+j] = frame_shadow[k*SIDE+j+1];
          frame_shadow[k*SIDE+LAST_POS] = r.glyph_rows[SIDE*k+s] ? colour : '0;
        end
        MODE_RIGHT: begin
          for (j = LAST_POS; j > 0; j--) frame_shadow[k*SIDE+j] = frame_shadow[k*SIDE+j-1];
          frame_shadow[k*SIDE] = r.glyph_rows[SIDE*k+(LAST_POS-s)] ? colour : '0;
        end
        MODE_UP: begin
          for (j = LAST_POS; j > 0; j--) frame_shadow[j*SIDE+k] = frame_shadow[(j-1)*SIDE+k];
          frame_shadow[k] = r.glyph_rows[SIDE*(LAST_POS-s)+k] ? colour : '0;
        end
        default: begin
          for (j = 0; j < LAST_POS; j++) frame_shadow[j*SIDE+k] = frame_shadow[(j+1)*SIDE+k];
          frame_shadow[LAST_POS*SIDE+k] = r.glyph_rows[SIDE*s+k] ? colour : '0;
        end
      endcase
    end
    for (p = 0; p < PIXEL_COUNT; p++) begin
      px.pixel_index = IDX_W'(p);
      px.pixel_red   = frame_shadow[p][23:16];
      px.pixel_green = frame_shadow[p][15:8];
      px.pixel_blue  = frame_shadow[p][7:0];
      px.frame_last  = (px.pixel_index == LAST_IDX);
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic step_req_t make_step(logic [1:0] mode, logic [63:0] glyph,
                                          logic [POS_W-1:0] step, logic [7:0] red,
                                          logic [7:0] green, logic [7:0] blue);
    step_req_t r;
    r.mode        = mode;
    r.glyph_rows  = glyph;
    r.step_index  = step;
    r.red_level   = red;
    r.green_level = green;
    r.blue_level  = blue;
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic issue_step(step_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    scroll_frame(r);
  endtask

  task automatic wait_frames_done();
    req_valid_i <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int n;
    issue_step(make_step(MODE_LEFT, 64'h0, 3'd0, 8'hFF, 8'hFF, 8'hFF));
    issue_step(make_step(MODE_LEFT, '1, 3'd7, 8'hFF, 8'hFF, 8'hFF));
    issue_step(make_step(MODE_RIGHT, '1, 3'd0, 8'hFF, 8'h00, 8'h00));
    issue_step(make_step(MODE_UP, 64'hAAAA_AAAA_AAAA_AAAA, 3'd3, 8'h00, 8'hFF, 8'h00));
    issue_step(make_step(MODE_DOWN, 64'h5555_5555_5555_5555, 3'd4, 8'h00, 8'h00, 8'hFF));
    issue_step(make_step(MODE_LEFT, 64'h0123_4567_89AB_CDEF, 3'd1, 8'h12, 8'h34, 8'h56));
    issue_step(make_step(MODE_RIGHT, 64'hFEDC_BA98_7654_3210, 3'd6, 8'hAB, 8'hCD, 8'hEF));
    issue_step(make_step(MODE_UP, '1, 3'd7, 8'h01, 8'h80, 8'h7F));
    issue_step(make_step(MODE_DOWN, '1, 3'd0, 8'h80, 8'h01, 8'hFE));
    issue_step(make_step(MODE_UP, 64'h0, 3'd0, 8'hFF, 8'hFF, 8'hFF));
    issue_step(make_step(MODE_DOWN, 64'h8000_0000_0000_0001, 3'd7, 8'h5A, 8'hA5, 8'h3C));
    issue_step(make_step(MODE_RIGHT, 64'h0000_0000_0000_0080, 3'd0, 8'hC3, 8'h3C, 8'h99));
    for (n = 0; n < SIDE; n++) begin
      issue_step(make_step(MODE_LEFT, 64'h3C66_7E66_663C_1800, POS_W'(n),
                           8'hFF, 8'h40, 8'h00));
    end
  endtask

  // sender holds off until the current frames are fully out, then resumes
  task automatic test_idle_restart();
    int n;
    for (n = 0; n < 3; n++) begin
      issue_step(make_step(2'($urandom_range(3)), {$urandom, $urandom},
                           POS_W'($urandom_range(7)), 8'($urandom), 8'($urandom),
                           8'($urandom)));
    end
    wait_frames_done();
    for (n = 0; n < 3; n++) begin
      issue_step(make_step(2'($urandom_range(3)), {$urandom, $urandom},
                           POS_W'($urandom_range(7)), 8'($urandom), 8'($urandom),
                           8'($urandom)));
    end
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
    int          sent;
    int          n;
    logic [1:0]  mode;
    logic [63:0] glyph;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          reverse;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      mode  = 2'($urandom_range(3));
      glyph = {$urandom, $urandom};
      red   = 8'($urandom);
      green = 8'($urandom);
      blue  = 8'($urandom);
      if ($urandom_range(9) < 7) begin
        // whole glyph scrolled in, column by column or row by row
        reverse = 1'($urandom_range(1));
        for (n = 0; n < SIDE; n++) begin
          issue_step(make_step(mode, glyph, reverse ? POS_W'(LAST_POS - n) : POS_W'(n),
                               red, green, blue));
        end
        sent += SIDE;
      end else begin
        issue_step(make_step(mode, glyph, POS_W'($urandom_range(7)), red, green, blue));
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_valid_o && pix_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel %0d arrived with no request outstanding", pix_o.pixel_index);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_o.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, pix_o.pixel_index);
          error_count++;
        end
        if (pix_o.pixel_red !== want.pixel_red) begin
          $error("pixel_red: expected %0h, got %0h", want.pixel_red, pix_o.pixel_red);
          error_count++;
        end
        if (pix_o.pixel_green !== want.pixel_green) begin
          $error("pixel_green: expected %0h, got %0h", want.pixel_green, pix_o.pixel_green);
          error_count++;
        end
        if (pix_o.pixel_blue !== want.pixel_blue) begin
          $error("pixel_blue: expected %0h, got %0h", want.pixel_blue, pix_o.pixel_blue);
          error_count++;
        end
        if (pix_o.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, pix_o.frame_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (pix_valid_o && pix_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int p;
    for (p = 0; p < PIXEL_COUNT; p++) frame_shadow[p] = '0;
    tx_idle_pct = 22;
    rx_idle_pct = 68;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_restart();
    test_random_traffic(22, 68, 24);
    test_random_traffic(68, 22, 24);
    test_random_traffic(0, 0, 24);
    wait_frames_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
